// ===== sv/charger_pin_status_classifier_core_defines.svh =====
// assertion macros shared by the charger pin status classifier checker
`ifndef CHARGER_PIN_STATUS_CLASSIFIER_CORE_DEFINES_SVH
`define CHARGER_PIN_STATUS_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define CPSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define CPSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/cpsc_pkg.sv =====
// types and constants for the charger pin status classifier
package cpsc_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_HOLD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALT_WINDOW   = 2'd3;

  // register reset values
  localparam logic             RST_DETECT_LEVEL = 1'b0;
  localparam logic [CFG_W-1:0] RST_POWER_HOLD   = 16'd3000;
  localparam logic [CFG_W-1:0] RST_STABLE       = 16'd500;
  localparam logic [CFG_W-1:0] RST_ALT_WINDOW   = 16'd2000;

  typedef enum logic [1:0] {
    ST_NO_POWER   = 2'd0,
    ST_NO_BATTERY = 2'd1,
    ST_CHARGING   = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  typedef struct packed {
    logic [CFG_W-1:0] power_hold;
    logic [CFG_W-1:0] stable;
    logic [CFG_W-1:0] alt_window;
  } cfg_t;

  // pin history, as seen after the current tick is folded in
  typedef struct packed {
    logic [TIME_W-1:0] power_time;
    logic              power_valid;
    logic [TIME_W-1:0] detect_time;
    logic              detect_valid;
    logic [TIME_W-1:0] full_time;
    logic              full_valid;
    logic [TIME_W-1:0] detect_since;
    logic              detect_active;
    logic [TIME_W-1:0] full_since;
    logic              full_active;
  } hist_t;

  typedef struct packed {
    status_t status;
    logic    power;
    logic    charging;
    logic    full;
    logic    batt_missing;
  } result_t;

endpackage

// ===== sv/cpsc_track.sv =====
// pin history registers: last-seen and active-since times per pin
module cpsc_track (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      upd,
  input  logic [cpsc_pkg::TIME_W-1:0] now,
  input  logic                      det,
  input  logic                      ful,
  output cpsc_pkg::hist_t           hist_next
);
  import cpsc_pkg::*;

  hist_t hist;

  // fold the current tick into the stored history
  always_comb begin
    hist_next = hist;
    if (det || ful) begin
      hist_next.power_time  = now;
      hist_next.power_valid = 1'b1;
    end
    if (det) begin
      hist_next.detect_time  = now;
      hist_next.detect_valid = 1'b1;
      if (!hist.detect_active) begin
        hist_next.detect_since = now;
      end
    end
    hist_next.detect_active = det;
    if (ful) begin
      hist_next.full_time  = now;
      hist_next.full_valid = 1'b1;
      if (!hist.full_active) begin
        hist_next.full_since = now;
      end
    end
    hist_next.full_active = ful;
  end

  // history register, cleared to never seen
  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (upd) begin
      hist <= hist_next;
    end
  end

endmodule

// ===== sv/cpsc_classify.sv =====
// window tests and priority pick of the charger state
module cpsc_classify (
  input  logic [cpsc_pkg::TIME_W-1:0] now,
  input  cpsc_pkg::hist_t             hist,
  input  cpsc_pkg::cfg_t              cfg,
  output cpsc_pkg::result_t           res
);
  import cpsc_pkg::*;

  logic [TIME_W-1:0] power_age;
  logic [TIME_W-1:0] detect_age;
  logic [TIME_W-1:0] full_age;
  logic [TIME_W-1:0] detect_run;
  logic [TIME_W-1:0] full_run;
  logic [TIME_W-1:0] hold_ext;
  logic [TIME_W-1:0] stable_ext;
  logic [TIME_W-1:0] window_ext;
  logic              pwr;
  logic              det_stable;
  logic              ful_stable;
  logic              alt;
  logic              nobat;
  status_t           status;

  // elapsed times wrap modulo 2^32
  assign power_age  = now - hist.power_time;
  assign detect_age = now - hist.detect_time;
  assign full_age   = now - hist.full_time;
  assign detect_run = now - hist.detect_since;
  assign full_run   = now - hist.full_since;

  assign hold_ext   = {{(TIME_W-CFG_W){1'b0}}, cfg.power_hold};
  assign stable_ext = {{(TIME_W-CFG_W){1'b0}}, cfg.stable};
  assign window_ext = {{(TIME_W-CFG_W){1'b0}}, cfg.alt_window};

  // window tests
  assign pwr        = hist.power_valid && (power_age <= hold_ext);
  assign det_stable = hist.detect_active && (detect_run >= stable_ext);
  assign ful_stable = hist.full_active && (full_run >= stable_ext);
  assign alt        = pwr && hist.detect_valid && hist.full_valid &&
                      (detect_age <= window_ext) && (full_age <= window_ext);
  assign nobat      = alt && !det_stable && !ful_stable;

  // state by priority
  always_comb begin
    if (!pwr) begin
      status = ST_NO_POWER;
    end else if (nobat) begin
      status = ST_NO_BATTERY;
    end else if (det_stable) begin
      status = ST_CHARGING;
    end else if (ful_stable) begin
      status = ST_FULL;
    end else begin
      status = ST_CHARGING;
    end
  end

  assign res.status       = status;
  assign res.power        = pwr;
  assign res.charging     = (status == ST_CHARGING) || (status == ST_NO_BATTERY);
  assign res.full         = (status == ST_FULL);
  assign res.batt_missing = nobat;

endmodule

// ===== sv/charger_pin_status_classifier_core.sv =====
// Charger pin status classifier: one tick (timestamp plus detect and standby
// pin levels) in, one status result out. A tick is registered on transfer,
// then the pin history update, the hold/stable/alternation window tests and
// the priority pick run combinationally into the result register, and one
// tick can be taken every cycle while the output is not stalled. Input
// ready follows output ready combinationally when both registers are full;
// a stalled output holds the pipe without losing a tick. The changed bit
// compares the packed state and flags with those of the previous tick
// (reset: no power, all flags clear). Configuration writes take effect on
// the next cycle and are meant for idle periods only.
module charger_pin_status_classifier_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [cpsc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [cpsc_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cpsc_pkg::TIME_W-1:0]    now_ms,
  input  logic                           detect_level,
  input  logic                           full_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     status_code,
  output logic                           power_ok,
  output logic                           charging_flag,
  output logic                           full_flag,
  output logic                           no_battery_flag,
  output logic                           changed
);
  import cpsc_pkg::*;

  logic              detect_active_level;
  cfg_t              cfg;
  logic              s1_valid;
  logic [TIME_W-1:0] s1_now;
  logic              s1_detect;
  logic              s1_full;
  logic              adv;
  logic              upd;
  logic              det;
  hist_t             hist_next;
  result_t           res;
  logic [5:0]        snap;
  logic [5:0]        last_snapshot;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      detect_active_level <= RST_DETECT_LEVEL;
      cfg.power_hold      <= RST_POWER_HOLD;
      cfg.stable          <= RST_STABLE;
      cfg.alt_window      <= RST_ALT_WINDOW;
    end else if (cfg_write) begin
      case (cfg_addr)
        CFG_DETECT_LEVEL: detect_active_level <= cfg_wdata[0];
        CFG_POWER_HOLD:   cfg.power_hold      <= cfg_wdata;
        CFG_STABLE:       cfg.stable          <= cfg_wdata;
        CFG_ALT_WINDOW:   cfg.alt_window      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipe control
  assign adv      = !out_valid || out_ready;
  assign in_ready = !s1_valid || adv;
  assign upd      = s1_valid && adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_now    <= now_ms;
      s1_detect <= detect_level;
      s1_full   <= full_level;
    end
  end

  assign det = (s1_detect == detect_active_level);

  cpsc_track u_track (
    .clk       (clk),
    .rst       (rst),
    .upd       (upd),
    .now       (s1_now),
    .det       (det),
    .ful       (s1_full),
    .hist_next (hist_next)
  );

  cpsc_classify u_classify (
    .now  (s1_now),
    .hist (hist_next),
    .cfg  (cfg),
    .res  (res)
  );

  assign snap = {res.batt_missing, res.full, res.charging, res.power, res.status};

  // result register and previous snapshot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      last_snapshot <= '0;
    end else begin
      if (adv) begin
        out_valid <= s1_valid;
      end
      if (upd) begin
        last_snapshot <= snap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      status_code     <= res.status;
      power_ok        <= res.power;
      charging_flag   <= res.charging;
      full_flag       <= res.full;
      no_battery_flag <= res.batt_missing;
      changed         <= (snap != last_snapshot);
    end
  end

endmodule

// ===== sv/cpsc_checker.sv =====
// port-level checks for the charger pin status classifier, bound to the top
`include "charger_pin_status_classifier_core_defines.svh"

module cpsc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status_code,
  input logic       power_ok,
  input logic       charging_flag,
  input logic       full_flag,
  input logic       no_battery_flag
);
  import cpsc_pkg::*;

  logic st_none;
  logic st_nobat;
  logic st_chg;
  logic st_full;

  // decoded state on the result port
  assign st_none  = (status_code == ST_NO_POWER);
  assign st_nobat = (status_code == ST_NO_BATTERY);
  assign st_chg   = (status_code == ST_CHARGING) || st_nobat;
  assign st_full  = (status_code == ST_FULL);

  // no power state exactly when power is absent
  `CPSC_ASSERT_NOW(a_power_state, out_valid, st_none == !power_ok, "power flag vs state")

  // flags follow the state
  `CPSC_ASSERT_NOW(a_full_flag, out_valid, full_flag == st_full, "full flag vs state")
  `CPSC_ASSERT_NOW(a_charging_flag, out_valid, charging_flag == st_chg, "charging flag vs state")
  `CPSC_ASSERT_NOW(a_no_battery_flag, out_valid, no_battery_flag == st_nobat, "no battery vs state")

  // a stalled result is not dropped
  `CPSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

endmodule

bind charger_pin_status_classifier_core cpsc_checker u_checker (.*);

// ===== verif/tb_charger_pin_status_classifier_core.sv =====
// testbench for the charger pin status classifier core: directed, config, random and backpressure ticks
module tb_charger_pin_status_classifier_core;
  import cpsc_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned TICKS_PER_PHASE = 120;

  typedef enum {PAT_CHARGE, PAT_FULL, PAT_ALTERNATE, PAT_OFF, PAT_NOISE} pin_pattern_t;
  typedef enum {RDY_ALWAYS, RDY_COIN, RDY_RARE_STALL, RDY_PERIODIC} ready_mode_t;

  typedef struct {
    result_t res;
    logic    changed;
  } status_snapshot_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [TIME_W-1:0]    now_ms;
  logic                 detect_level;
  logic                 full_level;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           status_code;
  logic                 power_ok;
  logic                 charging_flag;
  logic                 full_flag;
  logic                 no_battery_flag;
  logic                 changed;

  charger_pin_status_classifier_core i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .now_ms          (now_ms),
    .detect_level    (detect_level),
    .full_level      (full_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status_code     (status_code),
    .power_ok        (power_ok),
    .charging_flag   (charging_flag),
    .full_flag       (full_flag),
    .no_battery_flag (no_battery_flag),
    .changed         (changed)
  );

  // predictor copy of the registers
  logic             m_det_level = RST_DETECT_LEVEL;
  logic [CFG_W-1:0] m_hold      = RST_POWER_HOLD;
  logic [CFG_W-1:0] m_stable    = RST_STABLE;
  logic [CFG_W-1:0] m_alt       = RST_ALT_WINDOW;

  // predictor copy of the pin history
  logic [TIME_W-1:0] pw_time   = '0;
  logic              pw_seen   = 1'b0;
  logic [TIME_W-1:0] det_time  = '0;
  logic              det_seen  = 1'b0;
  logic [TIME_W-1:0] ful_time  = '0;
  logic              ful_seen  = 1'b0;
  logic [TIME_W-1:0] det_since = '0;
  logic              det_on    = 1'b0;
  logic [TIME_W-1:0] ful_since = '0;
  logic              ful_on    = 1'b0;
  logic [5:0]        prev_snap = '0;

  status_snapshot_t pending_status_q[$];
  int unsigned      mismatch_count = 0;
  int unsigned      result_count = 0;
  int unsigned      burst_left = 0;
  bit               hold_gaps = 1'b0;
  bit               hold_req = 1'b0;
  logic [TIME_W-1:0] tick_now = '0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [TIME_W-1:0] elapsed_ms(input logic [TIME_W-1:0] t,
                                                   input logic [TIME_W-1:0] then_t);
    return t - then_t;
  endfunction

  // fold one tick into the pin history and pick the expected status
  function automatic status_snapshot_t classify_tick(input logic [TIME_W-1:0] t,
                                                     input logic det_raw,
                                                     input logic ful_raw);
    logic             det_act;
    logic             pwr;
    logic             det_stable;
    logic             ful_stable;
    logic             alt;
    logic             nobat;
    status_t          st;
    logic [5:0]       snap;
    status_snapshot_t r;
    det_act = (det_raw == m_det_level);
    if (det_act) begin
      pw_time  = t;
      pw_seen  = 1'b1;
      det_time = t;
      det_seen = 1'b1;
      if (!det_on) begin
        det_since = t;
        det_on    = 1'b1;
      end
    end else begin
      det_on    = 1'b0;
      det_since = '0;
    end
    if (ful_raw) begin
      pw_time  = t;
      pw_seen  = 1'b1;
      ful_time = t;
      ful_seen = 1'b1;
      if (!ful_on) begin
        ful_since = t;
        ful_on    = 1'b1;
      end
    end else begin
      ful_on    = 1'b0;
      ful_since = '0;
    end
    pwr        = pw_seen && (elapsed_ms(t, pw_time) <= {16'd0, m_hold});
    det_stable = det_on && (elapsed_ms(t, det_since) >= {16'd0, m_stable});
    ful_stable = ful_on && (elapsed_ms(t, ful_since) >= {16'd0, m_stable});
    alt        = pwr && det_seen && ful_seen &&
                 (elapsed_ms(t, det_time) <= {16'd0, m_alt}) &&
                 (elapsed_ms(t, ful_time) <= {16'd0, m_alt});
    nobat      = alt && !det_stable && !ful_stable;
    if (!pwr)
      st = ST_NO_POWER;
    else if (nobat)
      st = ST_NO_BATTERY;
    else if (det_stable)
      st = ST_CHARGING;
    else if (ful_stable)
      st = ST_FULL;
    else
      st = ST_CHARGING;
    r.res.status       = st;
    r.res.power        = pwr;
    r.res.charging     = (st == ST_CHARGING) || (st == ST_NO_BATTERY);
    r.res.full         = (st == ST_FULL);
    r.res.batt_missing = nobat;
    snap = {r.res.batt_missing, r.res.full, r.res.charging, r.res.power, st};
    r.changed = (snap != prev_snap);
    prev_snap = snap;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("mismatch at result %0d: %s got %0h expected %0h", result_count, what, got,
             want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch(what, got, want);
  endtask

  // result checker: each result transfer against the oldest expected status
  always @(posedge clk) begin
    status_snapshot_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_status_q.size() == 0) begin
        report_mismatch("result with no tick pending", {30'd0, status_code}, 32'd0);
      end else begin
        want = pending_status_q.pop_front();
        check_field("status_code", 32'(status_code), 32'(want.res.status));
        check_field("power_ok", 32'(power_ok), 32'(want.res.power));
        check_field("charging_flag", 32'(charging_flag), 32'(want.res.charging));
        check_field("full_flag", 32'(full_flag), 32'(want.res.full));
        check_field("no_battery_flag", 32'(no_battery_flag), 32'(want.res.batt_missing));
        check_field("changed", 32'(changed), 32'(want.changed));
      end
      result_count++;
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    int unsigned quiet;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // receiver: ready pattern of its own, plus a long hold-off on request
  initial begin
    int unsigned cyc;
    int unsigned hold_cnt;
    ready_mode_t mode;
    cyc      = 0;
    hold_cnt = 0;
    mode     = RDY_ALWAYS;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_cnt == 0) begin
        hold_cnt = HOLD_OFF_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        if (cyc % 50 == 0)
          mode = ready_mode_t'($urandom_range(0, 3));
        case (mode)
          RDY_ALWAYS:     out_ready <= 1'b1;
          RDY_COIN:       out_ready <= 1'($urandom_range(0, 1));
          RDY_RARE_STALL: out_ready <= ($urandom_range(0, 7) != 0);
          default:        out_ready <= ((cyc % 5) < 3);
        endcase
      end
      cyc++;
    end
  end

  // offer one tick, hold it until transfer, then maybe idle between bursts
  task automatic send_tick(input logic [TIME_W-1:0] t, input logic det_raw,
                           input logic ful_raw);
    int unsigned gap;
    in_valid     <= 1'b1;
    now_ms       <= t;
    detect_level <= det_raw;
    full_level   <= ful_raw;
    do @(posedge clk); while (!in_ready);
    pending_status_q.push_back(classify_tick(t, det_raw, ful_raw));
    if (burst_left != 0)
      burst_left--;
    if (burst_left == 0 && !hold_gaps) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // pins given as active or not, mapped through the detect polarity
  task automatic send_pins(input logic [TIME_W-1:0] t, input logic det_act,
                           input logic ful_act);
    send_tick(t, det_act ? m_det_level : ~m_det_level, ful_act);
  endtask

  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (pending_status_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_DETECT_LEVEL: m_det_level = val[0];
      CFG_POWER_HOLD:   m_hold      = val;
      CFG_STABLE:       m_stable    = val;
      default:          m_alt       = val;
    endcase
    @(posedge clk);
  endtask

  // all four registers, only while nothing is in flight
  task automatic write_config(input logic [CFG_W-1:0] level, input logic [CFG_W-1:0] hold,
                              input logic [CFG_W-1:0] stable, input logic [CFG_W-1:0] alt);
    wait_until_idle();
    set_reg(CFG_DETECT_LEVEL, level);
    set_reg(CFG_POWER_HOLD, hold);
    set_reg(CFG_STABLE, stable);
    set_reg(CFG_ALT_WINDOW, alt);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_cfg_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return CFG_W'($urandom_range(0, 65535));
      default: return CFG_W'($urandom_range(1, 3000));
    endcase
  endfunction

  // thresholds, inclusive edges, wrap, backwards time, alternation at reset config
  task automatic test_directed_cases();
    send_pins(32'd0, 1'b0, 1'b0);          // first tick equals reset snapshot
    send_pins(32'd100, 1'b1, 1'b0);
    send_pins(32'd599, 1'b1, 1'b0);        // one short of stable
    send_pins(32'd600, 1'b1, 1'b0);        // stable exactly
    send_pins(32'd700, 1'b0, 1'b1);        // both seen, none stable
    send_pins(32'd1200, 1'b0, 1'b1);       // full stable
    send_pins(32'd1300, 1'b1, 1'b1);
    send_pins(32'd1800, 1'b1, 1'b1);       // both stable, detect wins
    send_pins(32'd4800, 1'b0, 1'b0);       // hold edge, inclusive
    send_pins(32'd4801, 1'b0, 1'b0);       // just past hold
    send_pins(32'd4000, 1'b0, 1'b0);       // time going backwards
    send_pins(32'hFFFF_FF00, 1'b1, 1'b0);
    send_pins(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_pins(32'h0000_0100, 1'b1, 1'b0);  // stable across the wrap
    send_pins(32'h0000_0150, 1'b0, 1'b1);
    send_pins(32'h0000_0151, 1'b1, 1'b1);
    send_tick(32'h0000_0152, 1'b1, 1'b0);  // raw high detect is inactive here
    tick_now = 32'h0000_0152;
  endtask

  // zero and full-scale windows, polarity write with extra bits masked
  task automatic test_config_extremes();
    write_config(16'hFFFF, 16'd0, 16'd0, 16'd0);
    send_pins(32'd10, 1'b1, 1'b0);
    send_pins(32'd10, 1'b0, 1'b1);
    send_pins(32'd11, 1'b0, 1'b0);
    send_pins(32'd11, 1'b1, 1'b1);
    send_tick(32'd12, 1'b0, 1'b0);         // raw low detect is inactive now
    write_config(16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pins(32'd0, 1'b1, 1'b0);
    send_pins(32'd65534, 1'b1, 1'b0);
    send_pins(32'd65535, 1'b1, 1'b0);
    send_pins(32'd65536, 1'b0, 1'b1);
    send_pins(32'd131071, 1'b0, 1'b0);
    send_pins(32'd131072, 1'b0, 1'b0);
    tick_now = 32'd131072;
    write_config({15'd0, RST_DETECT_LEVEL}, RST_POWER_HOLD, RST_STABLE, RST_ALT_WINDOW);
  endtask

  // pin patterns with timestamps aimed at the window edges
  task automatic test_random_sequences();
    pin_pattern_t      pat;
    int unsigned       seg_left;
    int unsigned       scale;
    logic [TIME_W-1:0] d;
    logic              phase_bit;
    logic              det_act;
    logic              ful_act;
    seg_left  = 0;
    phase_bit = 1'b0;
    pat       = PAT_CHARGE;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_config(CFG_W'($urandom_range(0, 65535)), pick_cfg_value(), pick_cfg_value(),
                   pick_cfg_value());
      scale = {16'd0, m_hold};
      if (m_stable > scale)
        scale = {16'd0, m_stable};
      if (m_alt > scale)
        scale = {16'd0, m_alt};
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        if (seg_left == 0) begin
          pat      = pin_pattern_t'($urandom_range(0, 4));
          seg_left = $urandom_range(3, 25);
        end
        seg_left--;
        // next timestamp
        d = $urandom_range(0, 2);
        case ($urandom_range(0, 15))
          0:       ;
          1:       tick_now = $urandom();
          2:       tick_now = det_since + m_stable + d - 32'd1;
          3:       tick_now = ful_since + m_stable + d - 32'd1;
          4:       tick_now = pw_time + m_hold + d - 32'd1;
          5:       tick_now = det_time + m_alt + d - 32'd1;
          6:       tick_now = ful_time + m_alt + d - 32'd1;
          default: tick_now = tick_now + $urandom_range(0, scale / 8 + 2);
        endcase
        // pin levels for the current pattern
        det_act = 1'b0;
        ful_act = 1'b0;
        case (pat)
          PAT_CHARGE: begin
            det_act = 1'b1;
            ful_act = ($urandom_range(0, 9) == 0);
          end
          PAT_FULL: begin
            ful_act = 1'b1;
            det_act = ($urandom_range(0, 9) == 0);
          end
          PAT_ALTERNATE: begin
            phase_bit = ~phase_bit;
            det_act   = phase_bit;
            ful_act   = ~phase_bit | ($urandom_range(0, 7) == 0);
          end
          PAT_OFF: ;
          default: begin
            det_act = 1'($urandom_range(0, 1));
            ful_act = 1'($urandom_range(0, 1));
          end
        endcase
        if (pat == PAT_NOISE)
          send_tick(tick_now, 1'($urandom_range(0, 1)), ful_act);
        else
          send_pins(tick_now, det_act, ful_act);
      end
    end
  endtask

  // receiver holds off while ticks keep coming, so the input stalls
  task automatic test_output_backpressure();
    wait_until_idle();
    hold_gaps = 1'b1;
    hold_req  = 1'b1;
    for (int n = 0; n < 40; n++) begin
      tick_now = tick_now + $urandom_range(0, 300);
      send_pins(tick_now, (n % 8) < 5, (n % 3) == 0);
    end
    hold_gaps = 1'b0;
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_addr     <= CFG_DETECT_LEVEL;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    now_ms       <= '0;
    detect_level <= 1'b0;
    full_level   <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_config_extremes();
    test_random_sequences();
    test_output_backpressure();
    wait_until_idle();
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
